// ----- rtl/core/nec_ipd_pkg.sv -----
// Shared types and constants for the NEC IR pulse interval decoder.
// Used by every module under rtl/core; no dependencies of its own.
package nec_ipd_pkg;

  localparam int unsigned FRAME_BITS_DEF = 32;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned PADDR_W        = 5;
  localparam int unsigned PDATA_W        = 32;
  localparam int unsigned REG_IDX_W      = 3;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_HDR_MIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HDR_MAX    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ONE_MAX    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MATCH_ADDR = 3'd6;

  // Register reset values
  localparam logic [CFG_W-1:0] HDR_MIN_RST    = 16'd12000;
  localparam logic [CFG_W-1:0] HDR_MAX_RST    = 16'd15000;
  localparam logic [CFG_W-1:0] ONE_MIN_RST    = 16'd2000;
  localparam logic [CFG_W-1:0] ONE_MAX_RST    = 16'd2700;
  localparam logic [CFG_W-1:0] ZERO_MIN_RST   = 16'd900;
  localparam logic [CFG_W-1:0] ZERO_MAX_RST   = 16'd1400;
  localparam logic [CFG_W-1:0] MATCH_ADDR_RST = 16'h474D;

  typedef struct packed {
    logic [CFG_W-1:0] hdr_min;
    logic [CFG_W-1:0] hdr_max;
    logic [CFG_W-1:0] one_min;
    logic [CFG_W-1:0] one_max;
    logic [CFG_W-1:0] zero_min;
    logic [CFG_W-1:0] zero_max;
    logic [CFG_W-1:0] match_addr;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              hit;
  } res_t;

endpackage

// ----- rtl/core/nec_ipd_regs.sv -----
// APB-style configuration register file for the NEC IR decoder.
// Depends on nec_ipd_pkg for register indexes, reset values and cfg_t.
module nec_ipd_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nec_ipd_pkg::PADDR_W-1:0] paddr,
  input  logic [nec_ipd_pkg::PDATA_W-1:0] pwdata,
  output logic [nec_ipd_pkg::PDATA_W-1:0] prdata,
  output logic                           pready,
  output nec_ipd_pkg::cfg_t              cfg_o
);
  import nec_ipd_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [CFG_W-1:0]     wr_val;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_val  = pwdata[CFG_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_HDR_MIN:    cfg_d.hdr_min    = wr_val;
        REG_HDR_MAX:    cfg_d.hdr_max    = wr_val;
        REG_ONE_MIN:    cfg_d.one_min    = wr_val;
        REG_ONE_MAX:    cfg_d.one_max    = wr_val;
        REG_ZERO_MIN:   cfg_d.zero_min   = wr_val;
        REG_ZERO_MAX:   cfg_d.zero_max   = wr_val;
        REG_MATCH_ADDR: cfg_d.match_addr = wr_val;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HDR_MIN:    prdata = PDATA_W'(cfg_q.hdr_min);
      REG_HDR_MAX:    prdata = PDATA_W'(cfg_q.hdr_max);
      REG_ONE_MIN:    prdata = PDATA_W'(cfg_q.one_min);
      REG_ONE_MAX:    prdata = PDATA_W'(cfg_q.one_max);
      REG_ZERO_MIN:   prdata = PDATA_W'(cfg_q.zero_min);
      REG_ZERO_MAX:   prdata = PDATA_W'(cfg_q.zero_max);
      REG_MATCH_ADDR: prdata = PDATA_W'(cfg_q.match_addr);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_min    <= HDR_MIN_RST;
      cfg_q.hdr_max    <= HDR_MAX_RST;
      cfg_q.one_min    <= ONE_MIN_RST;
      cfg_q.one_max    <= ONE_MAX_RST;
      cfg_q.zero_min   <= ZERO_MIN_RST;
      cfg_q.zero_max   <= ZERO_MAX_RST;
      cfg_q.match_addr <= MATCH_ADDR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/nec_ipd_core.sv -----
// Input register and single-pass interval decode for the NEC IR decoder.
// Depends on nec_ipd_pkg for cfg_t, res_t and widths.
module nec_ipd_core #(
  parameter int unsigned FRAME_BITS = nec_ipd_pkg::FRAME_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [nec_ipd_pkg::WORD_W-1:0] edge_time_us_i,
  input  nec_ipd_pkg::cfg_t             cfg_i,
  input  logic                          out_free_i,
  output logic                          res_load_o,
  output nec_ipd_pkg::res_t             res_o
);
  import nec_ipd_pkg::*;

  localparam int unsigned CntW = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(FRAME_BITS - 1);

  function automatic logic in_window(logic [WORD_W-1:0] gap, logic [CFG_W-1:0] lo,
                                     logic [CFG_W-1:0] hi);
    return (gap > WORD_W'(lo)) && (gap < WORD_W'(hi));
  endfunction

  logic                  s1_valid_q, s1_valid_d;
  logic [WORD_W-1:0]     s1_time_q, s1_time_d;
  logic [WORD_W-1:0]     prev_q, prev_d;
  logic [FRAME_BITS-1:0] acc_q, acc_d, acc_set;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  act_q, act_d;

  logic [WORD_W-1:0]     gap;
  logic                  hdr_hit, one_hit, zero_hit, bit_ok, emit, s1_go;
  logic [WORD_W-1:0]     word;

  assign gap      = s1_time_q - prev_q;
  assign hdr_hit  = in_window(gap, cfg_i.hdr_min, cfg_i.hdr_max);
  assign one_hit  = in_window(gap, cfg_i.one_min, cfg_i.one_max);
  assign zero_hit = in_window(gap, cfg_i.zero_min, cfg_i.zero_max);
  assign bit_ok   = act_q & ~hdr_hit & (one_hit | zero_hit);
  assign emit     = s1_valid_q & bit_ok & (cnt_q == LastCnt);
  // an item that closes a frame waits for room in the output register
  assign s1_go      = s1_valid_q & (~emit | out_free_i);
  assign in_stall_o = s1_valid_q & ~s1_go;

  always_comb begin
    acc_set = acc_q;
    if (one_hit) begin
      acc_set[cnt_q] = 1'b1;
    end
  end

  assign word       = WORD_W'(acc_set);
  assign res_load_o = emit & s1_go;
  assign res_o.word = word;
  assign res_o.hit  = (word[CFG_W-1:0] == cfg_i.match_addr);

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_time_d  = s1_time_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
      if (in_valid_i) begin
        s1_time_d = edge_time_us_i;
      end
    end
  end

  always_comb begin
    prev_d = prev_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    act_d  = act_q;
    if (s1_go) begin
      prev_d = s1_time_q;
      if (hdr_hit) begin
        act_d = 1'b1;
        cnt_d = '0;
        acc_d = '0;
      end else if (act_q) begin
        if (bit_ok && cnt_q != LastCnt) begin
          cnt_d = cnt_q + 1'b1;
          acc_d = acc_set;
        end else begin
          // frame done or aborted: close it
          act_d = 1'b0;
          cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_time_q  <= '0;
      prev_q     <= '0;
      acc_q      <= '0;
      cnt_q      <= '0;
      act_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_time_q  <= s1_time_d;
      prev_q     <= prev_d;
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
      act_q      <= act_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastCnt)
    else $error("bit counter beyond frame length");
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !act_q |-> cnt_q == '0)
    else $error("bit counter not cleared outside a frame");
  a_acc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q |-> (acc_q >> cnt_q) == '0)
    else $error("accumulator holds bits above the fill count");
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && emit && !out_free_i)
    else $error("input stalled without a pending frame result");
`endif

endmodule

// ----- rtl/core/nec_ipd_outreg.sv -----
// Result register for the NEC IR decoder: holds one frame until transferred.
// Depends on nec_ipd_pkg for res_t and widths.
module nec_ipd_outreg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  nec_ipd_pkg::res_t             res_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [nec_ipd_pkg::WORD_W-1:0] frame_word_o,
  output logic                          address_hit_o
);
  import nec_ipd_pkg::*;

  logic  valid_q, valid_d;
  res_t  res_q, res_d;

  assign free_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o   = valid_q;
  assign frame_word_o  = res_q.word;
  assign address_hit_o = res_q.hit;

endmodule

// ----- rtl/core/nec_ir_pulse_interval_decoder.sv -----
// Top level of the NEC IR pulse interval decoder.
// Depends on nec_ipd_pkg, nec_ipd_regs, nec_ipd_core and nec_ipd_outreg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one falling-edge timestamp
//   per transfer, in microseconds, wrapping modulo 2^32. Output channel
//   (out_valid_o / out_stall_i) carries one decoded frame per transfer: the
//   full word (first bit at bit zero), its address and command fields and an
//   address-match flag. Edges that do not complete a frame produce nothing.
//   Configuration: seven 16-bit registers on the APB port at byte address
//   4 * index (gap windows, exclusive bounds, and the match address); write
//   them only while no edge is in flight.
//   A frame's last edge sits in the input register, then decodes straight
//   into the result register, which drives out_valid_o; a full result
//   register with a stalled receiver can hold it in the input register.
//   Throughput: one edge per cycle while in_stall_o is low; each edge takes
//   one pass through the subtract-and-compare logic between the two registers.
//   When the receiver stalls, the result register holds the frame; further
//   edges keep flowing until an edge that closes another frame reaches the
//   decode stage, which then stalls the input until the result register frees.
//   Reset: registers return to their defaults, the previous edge time to zero
//   and no frame is open; both channels come up empty.
module nec_ir_pulse_interval_decoder #(
  parameter int unsigned FRAME_BITS = nec_ipd_pkg::FRAME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // edge timestamp channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [nec_ipd_pkg::WORD_W-1:0]  edge_time_us_i,
  // decoded frame channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [nec_ipd_pkg::WORD_W-1:0]  frame_word_o,
  output logic [nec_ipd_pkg::CFG_W-1:0]   frame_address_o,
  output logic [7:0]                     frame_command_o,
  output logic                           address_hit_o,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nec_ipd_pkg::PADDR_W-1:0] paddr,
  input  logic [nec_ipd_pkg::PDATA_W-1:0] pwdata,
  output logic [nec_ipd_pkg::PDATA_W-1:0] prdata,
  output logic                           pready
);
  import nec_ipd_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_load;
  logic out_free;

  // configuration registers
  nec_ipd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register, gap windows and bit accumulation
  nec_ipd_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .edge_time_us_i (edge_time_us_i),
    .cfg_i          (cfg),
    .out_free_i     (out_free),
    .res_load_o     (res_load),
    .res_o          (res)
  );

  // hold the finished frame until the receiver takes it
  nec_ipd_outreg u_outreg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_load),
    .res_i         (res),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_word_o  (frame_word_o),
    .address_hit_o (address_hit_o)
  );

  // address is the low half-word, command the next byte
  assign frame_address_o = frame_word_o[CFG_W-1:0];
  assign frame_command_o = frame_word_o[CFG_W+7:CFG_W];

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for nec_ir_pulse_interval_decoder: edge timestamps in, frames out.
// Depends on nec_ipd_pkg and the decoder RTL; predicts every frame and checks it field by field.
`timescale 1ns / 100ps

module tb;
  import nec_ipd_pkg::*;

  localparam int FRAME_LEN  = FRAME_BITS_DEF;
  localparam int NUM_REGS   = 7;
  localparam int PIPE_DEPTH = 2;     // input register, then result register
  localparam int DRAIN_MAX  = 5000;  // cycles allowed for the last frames to show up

  // One slot past the last register: writes there must change nothing.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CFG_W-1:0]  address;
    logic [7:0]        command;
    logic              hit;
  } frame_t;

  typedef enum int {
    NOISE_WIDE, NOISE_SHORT, NOISE_BOUND, NOISE_ZERO, NOISE_JUMP, NOISE_REPEAT
  } noise_e;

  // Tracks the decoder's state from the accepted edges and holds the frames still owed.
  class frame_tracker;
    logic [CFG_W-1:0]  regs [NUM_REGS];
    logic [WORD_W-1:0] last_edge;
    logic [WORD_W-1:0] accum;
    logic [5:0]        nbits;
    bit                in_frame;
    frame_t            frames_due [$];
    int                frames_predicted;
    int                failures;

    function new();
      regs[REG_HDR_MIN]    = HDR_MIN_RST;
      regs[REG_HDR_MAX]    = HDR_MAX_RST;
      regs[REG_ONE_MIN]    = ONE_MIN_RST;
      regs[REG_ONE_MAX]    = ONE_MAX_RST;
      regs[REG_ZERO_MIN]   = ZERO_MIN_RST;
      regs[REG_ZERO_MAX]   = ZERO_MAX_RST;
      regs[REG_MATCH_ADDR] = MATCH_ADDR_RST;
      last_edge        = '0;
      accum            = '0;
      nbits            = '0;
      in_frame         = 1'b0;
      frames_predicted = 0;
      failures         = 0;
    endfunction

    // Bounds are exclusive on both sides.
    static function bit in_window(logic [WORD_W-1:0] gap, logic [CFG_W-1:0] lo,
                                  logic [CFG_W-1:0] hi);
      return gap > 32'(lo) && gap < 32'(hi);
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx < NUM_REGS) regs[idx] = value;
    endfunction

    function void note_edge(logic [WORD_W-1:0] stamp);
      logic [WORD_W-1:0] gap;
      logic              bit_val;
      frame_t            due;
      gap       = stamp - last_edge;
      last_edge = stamp;
      // Header wins over the bit windows, even inside an open frame.
      if (in_window(gap, regs[REG_HDR_MIN], regs[REG_HDR_MAX])) begin
        in_frame = 1'b1;
        nbits    = '0;
        accum    = '0;
        return;
      end
      if (!in_frame) return;
      if (in_window(gap, regs[REG_ONE_MIN], regs[REG_ONE_MAX])) begin
        bit_val = 1'b1;
      end else if (in_window(gap, regs[REG_ZERO_MIN], regs[REG_ZERO_MAX])) begin
        bit_val = 1'b0;
      end else begin
        in_frame = 1'b0;
        return;
      end
      accum[nbits[4:0]] = bit_val;
      nbits             = nbits + 6'd1;
      if (nbits < FRAME_LEN) return;
      in_frame    = 1'b0;
      due.word    = accum;
      due.address = accum[15:0];
      due.command = accum[23:16];
      due.hit     = (accum[15:0] == regs[REG_MATCH_ADDR]);
      frames_due.push_back(due);
      frames_predicted++;
    endfunction

    function void check_frame(logic [WORD_W-1:0] word, logic [CFG_W-1:0] address,
                              logic [7:0] command, logic hit);
      frame_t due;
      if (frames_due.size() == 0) begin
        $error("unexpected frame: frame_word %h", word);
        failures++;
        return;
      end
      due = frames_due.pop_front();
      if (word !== due.word) begin
        $error("frame_word: expected %h, got %h", due.word, word);
        failures++;
      end
      if (address !== due.address) begin
        $error("frame_address: expected %h, got %h", due.address, address);
        failures++;
      end
      if (command !== due.command) begin
        $error("frame_command: expected %h, got %h", due.command, command);
        failures++;
      end
      if (hit !== due.hit) begin
        $error("address_hit: expected %b, got %b", due.hit, hit);
        failures++;
      end
    endfunction
  endclass

  // Every input starts at a known value; reset is held low from time zero.
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [WORD_W-1:0]   edge_time_us_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [WORD_W-1:0]   frame_word_o;
  logic [CFG_W-1:0]    frame_address_o;
  logic [7:0]          frame_command_o;
  logic                address_hit_o;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [PADDR_W-1:0]  paddr          = '0;
  logic [PDATA_W-1:0]  pwdata         = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  frame_tracker        sb;
  logic [WORD_W-1:0]   clock_us    = '0;  // running IR timestamp that the edges follow
  int                  edges_sent  = 0;
  int                  cycle_count = 0;

  nec_ir_pulse_interval_decoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .edge_time_us_i  (edge_time_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_word_o    (frame_word_o),
    .frame_address_o (frame_address_o),
    .frame_command_o (frame_command_o),
    .address_hit_o   (address_hit_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: stall at random with a chance of one in five, except for one long quiet stretch.
  always @(negedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_stall_i <= (cycle_count < 2500 || cycle_count >= 4500) &&
                   ($urandom_range(0, 99) < 20);
  end

  // Check each frame transfer at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_frame(frame_word_o, frame_address_o, frame_command_o, address_hit_o);
  end

  // Hard stop in case the block hangs on either channel.
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Edge channel
  // ---------------------------------------------------------------------------

  // Offer one edge, idling at random first unless edges_sent is in 400..649; return once the transfer happened.
  // Valid stays high after the transfer until the next call or release_input.
  task automatic push_edge(input logic [WORD_W-1:0] stamp);
    bit tx_idle_on;
    tx_idle_on = !(edges_sent >= 400 && edges_sent < 650);
    @(negedge clk_i);
    while (tx_idle_on && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    edge_time_us_i <= stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_edge(stamp);
    edges_sent++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Hold the sender until every owed frame has arrived.
  task automatic hold_until_drained();
    release_input();
    while (sb.frames_due.size() != 0) @(negedge clk_i);
  endtask

  // Drain, then let edges that close no frame clear the pipeline too.
  task automatic settle();
    hold_until_drained();
    repeat (PIPE_DEPTH + 2) @(negedge clk_i);
  endtask

  task automatic step_us(input logic [WORD_W-1:0] gap);
    clock_us = clock_us + gap;
    push_edge(clock_us);
  endtask

  task automatic jump_to(input logic [WORD_W-1:0] stamp);
    clock_us = stamp;
    push_edge(clock_us);
  endtask

  // ---------------------------------------------------------------------------
  // Gap selection
  // ---------------------------------------------------------------------------

  function automatic bit window_open(input int lo, input int hi);
    return hi > lo + 1;
  endfunction

  // Strictly inside (lo, hi) when that window can match, anything short otherwise.
  function automatic logic [WORD_W-1:0] pick_gap(input int lo, input int hi);
    if (window_open(lo, hi)) return $urandom_range(lo + 1, hi - 1);
    return $urandom_range(0, 65535);
  endfunction

  // True when a higher-priority window would swallow this bit gap.
  function automatic bit shadowed(input logic [WORD_W-1:0] gap, input bit use_one);
    if (frame_tracker::in_window(gap, sb.regs[REG_HDR_MIN], sb.regs[REG_HDR_MAX]))
      return 1'b1;
    return !use_one &&
           frame_tracker::in_window(gap, sb.regs[REG_ONE_MIN], sb.regs[REG_ONE_MAX]);
  endfunction

  // Gap for one data bit; fall back to the other window when the wanted one is empty.
  // A clean pick retries to stay clear of overlapping windows.
  function automatic logic [WORD_W-1:0] bit_gap(input logic value, input bit clean);
    bit                use_one;
    int                lo;
    int                hi;
    logic [WORD_W-1:0] gap;
    use_one = (value && window_open(int'(sb.regs[REG_ONE_MIN]), int'(sb.regs[REG_ONE_MAX]))) ||
              !window_open(int'(sb.regs[REG_ZERO_MIN]), int'(sb.regs[REG_ZERO_MAX]));
    lo  = use_one ? int'(sb.regs[REG_ONE_MIN]) : int'(sb.regs[REG_ZERO_MIN]);
    hi  = use_one ? int'(sb.regs[REG_ONE_MAX]) : int'(sb.regs[REG_ZERO_MAX]);
    gap = pick_gap(lo, hi);
    for (int k = 0; clean && k < 8 && shadowed(gap, use_one); k++) gap = pick_gap(lo, hi);
    return gap;
  endfunction

  // Header, then the first nbits bits of word, first bit first.
  task automatic send_frame(input logic [WORD_W-1:0] word, input int nbits, input bit clean);
    step_us(pick_gap(int'(sb.regs[REG_HDR_MIN]), int'(sb.regs[REG_HDR_MAX])));
    for (int i = 0; i < nbits; i++) step_us(bit_gap(word[i], clean));
  endtask

  task automatic send_noise();
    noise_e kind;
    kind = noise_e'($urandom_range(0, 5));
    case (kind)
      NOISE_WIDE:  step_us($urandom);
      NOISE_SHORT: step_us($urandom_range(0, 70000));
      // Land exactly on one of the window bounds.
      NOISE_BOUND: step_us(32'(sb.regs[$urandom_range(0, NUM_REGS - 2)]));
      NOISE_ZERO:  step_us('0);
      NOISE_JUMP:  jump_to($urandom);
      default: begin
        // Repeat-code shape: a header followed by a short gap between 2100 and 2400.
        step_us(pick_gap(int'(sb.regs[REG_HDR_MIN]), int'(sb.regs[REG_HDR_MAX])));
        step_us($urandom_range(2100, 2400));
      end
    endcase
  endtask

  // Mostly well-formed frames with random content, plus cut-off frames, noise and drain pauses.
  // A cut-off frame followed by a new one reopens a frame from inside a frame.
  // Run past the budget until enough frames have closed, within three budgets.
  task automatic run_random(input int budget, input int min_frames);
    int                start_edges;
    int                start_frames;
    int                pick;
    logic [WORD_W-1:0] word;
    start_edges  = edges_sent;
    start_frames = sb.frames_predicted;
    while (edges_sent - start_edges < budget ||
           (sb.frames_predicted - start_frames < min_frames &&
            edges_sent - start_edges < 3 * budget)) begin
      pick = $urandom_range(0, 99);
      word = $urandom;
      if ($urandom_range(0, 2) == 0) word[15:0] = sb.regs[REG_MATCH_ADDR];
      if (pick < 72)      send_frame(word, FRAME_LEN, $urandom_range(0, 3) != 0);
      else if (pick < 82) send_frame(word, $urandom_range(0, FRAME_LEN - 1), 1'b1);
      else if (pick < 84) hold_until_drained();
      else                send_noise();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // Setup cycle, then access cycle until pready; sample read data at that edge.
  task automatic reg_access(input logic [REG_IDX_W-1:0] idx, input logic wr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write with junk in the unused upper bits, then read the register back unless it is the spare slot.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    logic [15:0]        junk;
    junk = 16'($urandom);
    reg_access(idx, 1'b1, {junk, value}, rd);
    sb.set_reg(idx, value);
    if (idx != REG_SPARE) begin
      reg_access(idx, 1'b0, '0, rd);
      if (rd[CFG_W-1:0] !== value) begin
        $error("prdata of register %0d: expected %h, got %h", idx, value, rd[CFG_W-1:0]);
        sb.failures++;
      end
    end
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] hdr_min, input logic [CFG_W-1:0] hdr_max,
                              input logic [CFG_W-1:0] one_min, input logic [CFG_W-1:0] one_max,
                              input logic [CFG_W-1:0] zero_min,
                              input logic [CFG_W-1:0] zero_max,
                              input logic [CFG_W-1:0] match_addr);
    settle();
    write_reg(REG_HDR_MIN, hdr_min);
    write_reg(REG_HDR_MAX, hdr_max);
    write_reg(REG_ONE_MIN, one_min);
    write_reg(REG_ONE_MAX, one_max);
    write_reg(REG_ZERO_MIN, zero_min);
    write_reg(REG_ZERO_MAX, zero_max);
    write_reg(REG_MATCH_ADDR, match_addr);
    // Nothing lives past the last register; the predictor ignores this write too.
    write_reg(REG_SPARE, 16'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int wait_cycles;
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed edges at reset windows (header 12000..15000, one 2000..2700,
    // zero 900..1400, all exclusive).
    step_us(13000);             // header measured from time zero
    step_us(2350);
    step_us(1150);
    step_us(2000);              // exactly on one_min: abort
    step_us(2700);              // outside any frame: only the timestamp moves
    step_us(12001);
    step_us(2001);
    step_us(2699);
    step_us(901);
    step_us(1399);
    step_us(14999);             // header again inside an open frame: restart
    step_us(1400);              // exactly on zero_max: abort
    jump_to(32'hFFFF_FFFF);
    step_us(13500);             // header across the 2^32 wrap
    step_us(900);               // exactly on zero_min: abort
    step_us(15000);             // exactly on header_max: no header
    step_us(12000);             // exactly on header_min: no header
    step_us('0);                // zero gap: an edge with the same timestamp as the one before
    jump_to('0);

    run_random(200, 6);

    // Narrower windows, random address.
    apply_config(16'd8000, 16'd10000, 16'd1600, 16'd1800, 16'd500, 16'd700, 16'($urandom));
    run_random(180, 6);

    // Overlapping windows: header beats one, one beats zero.
    apply_config(16'd1000, 16'd2000, 16'd1500, 16'd3000, 16'd0, 16'd1600, 16'h0000);
    run_random(180, 4);

    // Empty windows first, then the widest possible: every in-range gap is a header, so no frame closes.
    apply_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
    apply_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random(60, 0);

    // Tiny header window, wide one window, zero window inverted: all-ones frames.
    apply_config(16'd0, 16'd10, 16'd10, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    run_random(150, 4);

    // Zero window one wide and so empty.
    apply_config(16'd8000, 16'd10000, 16'd1600, 16'd1800, 16'd1000, 16'd1001, 16'($urandom));
    run_random(150, 4);

    // Back to the reset windows, address zero; pause mid-run once more.
    apply_config(HDR_MIN_RST, HDR_MAX_RST, ONE_MIN_RST, ONE_MAX_RST, ZERO_MIN_RST,
                 ZERO_MAX_RST, 16'h0000);
    run_random(90, 3);
    hold_until_drained();
    run_random(90, 3);

    // Drain, then give the pipeline time to show any frame it should not send.
    release_input();
    for (wait_cycles = 0; sb.frames_due.size() != 0 && wait_cycles < DRAIN_MAX; wait_cycles++)
      @(negedge clk_i);
    repeat (4 * PIPE_DEPTH) @(negedge clk_i);
    if (sb.frames_due.size() != 0) begin
      $error("frames never delivered: %0d, first frame_word %h",
             sb.frames_due.size(), sb.frames_due[0].word);
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
